FILE: rtl/core/bcm_pkg.sv
// shared constants, types and helpers for the breath cycle metrics block
`timescale 1ns / 1ps
`default_nettype none
package bcm_pkg;

  // breath stage codes
  localparam logic [2:0] ST_INS1  = 3'd0;
  localparam logic [2:0] ST_INS3  = 3'd2;
  localparam logic [2:0] ST_REST1 = 3'd3;
  localparam logic [2:0] ST_REST2 = 3'd4;

  // peak pressure ring
  localparam int PEAK_DEPTH = 64;
  localparam int PEAK_AW    = $clog2(PEAK_DEPTH);

  // rest pressure ring, depth kept a power of two so the average is a shift
  localparam int REST_DEPTH = 8;
  localparam int REST_AW    = $clog2(REST_DEPTH);
  localparam int REST_SW    = 10 + REST_AW;

  // reciprocal of 100 for a 16-bit magnitude: floor(x * 5243 / 2^19)
  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam int          RECIP_SH  = 19;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CALC = 5'b00010,
    S_SCAN = 5'b00100,
    S_FIN  = 5'b01000,
    S_SEND = 5'b10000
  } state_t;

  typedef struct packed {
    logic               capture;
    logic               calc;
    logic               scan_rd;
    logic [PEAK_AW-1:0] scan_addr;
    logic               scan_fin;
  } cmd_t;

  typedef struct packed {
    logic iend;
  } sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -34'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/bcm_ctrl.sv
// sequencer for capture, update, peak ring scan and result hand-off
`timescale 1ns / 1ps
`default_nettype none
module bcm_ctrl import bcm_pkg::*; (
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_tvalid,
  output logic in_tready,
  output logic out_tvalid,
  input  wire  out_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t             state_r, state_nxt;
  logic [PEAK_AW-1:0] idx_r, idx_nxt;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    cmd           = '0;
    cmd.scan_addr = idx_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc  = 1'b1;
        idx_nxt   = '0;
        state_nxt = sts.iend ? S_SCAN : S_SEND;
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        idx_nxt     = idx_r + 1'b1;
        if (idx_r == PEAK_AW'(PEAK_DEPTH - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.scan_fin = 1'b1;
        state_nxt    = S_SEND;
      end
      S_SEND: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_SEND);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/bcm_dp.sv
// datapath: volume integration, flow peaks, pressure rings and reported values
`timescale 1ns / 1ps
`default_nettype none
module bcm_dp import bcm_pkg::*; (
  input  wire                 clk,
  input  wire                 rst_n,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  wire  [2:0]          in_stage,
  input  wire  signed [15:0]  in_flow_ml_s,
  input  wire  signed [15:0]  in_pressure_centi,
  input  wire  [15:0]         in_elapsed_ms,
  input  wire  signed [31:0]  in_arm_position,
  input  wire                 in_paused,
  output logic signed [31:0]  volume_ul,
  output logic signed [31:0]  vti_ul,
  output logic signed [31:0]  vte_ul,
  output logic [14:0]         pip_centi,
  output logic signed [16:0]  peep_centi,
  output logic [14:0]         insp_flow_peak,
  output logic signed [15:0]  exp_flow_peak,
  output logic signed [31:0]  swept_clicks,
  output logic                breath_start,
  output logic                insp_end
);

  // captured sample
  logic [2:0]         stage_r;
  logic signed [15:0] flow_r, pres_r;
  logic [15:0]        elapsed_r;
  logic signed [31:0] arm_r;
  logic               paused_r;

  // running state
  logic [2:0]         last_stage_r;
  logic signed [31:0] vol_r;
  logic signed [15:0] ins_run_r, exp_run_r;
  logic signed [31:0] start_r;
  logic [PEAK_AW-1:0] peak_slot_r;
  logic signed [9:0]  rest_r [REST_DEPTH];
  logic [REST_AW-1:0] rest_slot_r;

  // reported values
  logic signed [31:0] vti_r, vte_r, swept_r;
  logic [14:0]        pip_r, ins_rep_r;
  logic signed [16:0] peep_r;
  logic signed [15:0] exp_rep_r;
  logic               bstart_r, iend_r;

  // peak ring storage and scan pipeline
  logic signed [15:0] peak_mem [PEAK_DEPTH];
  logic [PEAK_DEPTH-1:0] peak_vld_r;
  logic signed [15:0] rd_data_r;
  logic               rd_hit_r, rd_vld_r;
  logic signed [15:0] top_r, top_nxt, scan_val;

  // update logic
  logic [2:0]         st;
  logic               bstart, iend, peep_mv;
  logic signed [32:0] prod;
  logic signed [31:0] vol0, vol_nxt, vte_nxt;
  logic signed [15:0] ins_nxt, exp_clr, exp_nxt;
  logic signed [REST_SW-1:0] rest_sum;
  logic signed [REST_SW+6:0] rest_x100;
  logic signed [16:0] peep_nxt;
  logic [16:0]        pres_mag;
  logic [29:0]        quo_full;
  logic signed [9:0]  quo;

  always_comb begin
    st      = (stage_r > ST_REST2) ? ST_REST2 : stage_r;
    bstart  = (last_stage_r != ST_INS1) && (st == ST_INS1);
    iend    = (last_stage_r <= ST_INS3) && (st >= ST_REST1);
    peep_mv = (last_stage_r == ST_REST2) && (st == ST_INS1);

    prod    = flow_r * $signed({1'b0, elapsed_r});
    vol0    = bstart ? 32'sd0 : vol_r;
    vol_nxt = sat32({{2{vol0[31]}}, vol0} + {prod[32], prod});
    vte_nxt = sat32({{2{vti_r[31]}}, vti_r} - {{2{vol_r[31]}}, vol_r});

    ins_nxt = ins_run_r;
    if (peep_mv) begin
      ins_nxt = 16'sd0;
    end else if (!iend && st <= ST_INS3 && flow_r > ins_run_r) begin
      ins_nxt = flow_r;
    end

    exp_clr = bstart ? 16'sd0 : exp_run_r;
    exp_nxt = (st >= ST_INS3 && flow_r < exp_clr) ? flow_r : exp_clr;

    // ring sum over the eight rest samples, truncated average of sum * 100
    rest_sum = '0;
    for (int i = 0; i < REST_DEPTH; i++) begin
      rest_sum = rest_sum + REST_SW'(rest_r[i]);
    end
    rest_x100 = (REST_SW + 7)'(rest_sum) * (REST_SW + 7)'(100);
    if (rest_x100 < 0) begin
      rest_x100 = rest_x100 + (REST_SW + 7)'(REST_DEPTH - 1);
    end
    peep_nxt = 17'(rest_x100 >>> REST_AW);

    // whole cmH2O, truncated toward zero
    pres_mag = pres_r[15] ? 17'(-{pres_r[15], pres_r}) : {1'b0, pres_r};
    quo_full = 30'(pres_mag) * 30'(RECIP_100);
    quo      = 10'(quo_full >> RECIP_SH);
    if (pres_r[15]) begin
      quo = -quo;
    end

    scan_val = rd_hit_r ? rd_data_r : 16'sd0;
    top_nxt  = (rd_vld_r && scan_val > top_r) ? scan_val : top_r;
  end

  assign sts.iend = iend;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      stage_r   <= in_stage;
      flow_r    <= in_flow_ml_s;
      pres_r    <= in_pressure_centi;
      elapsed_r <= in_elapsed_ms;
      arm_r     <= in_arm_position;
      paused_r  <= in_paused;
    end
    if (cmd.calc && st == ST_INS3) begin
      peak_mem[peak_slot_r] <= pres_r;
    end
    if (cmd.scan_rd) begin
      rd_data_r <= peak_mem[cmd.scan_addr];
      rd_hit_r  <= peak_vld_r[cmd.scan_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_stage_r <= ST_INS1;
      vol_r        <= '0;
      ins_run_r    <= '0;
      exp_run_r    <= '0;
      start_r      <= '0;
      peak_slot_r  <= '0;
      rest_slot_r  <= '0;
      for (int i = 0; i < REST_DEPTH; i++) begin
        rest_r[i] <= '0;
      end
      vti_r      <= '0;
      vte_r      <= '0;
      swept_r    <= '0;
      pip_r      <= '0;
      ins_rep_r  <= '0;
      peep_r     <= '0;
      exp_rep_r  <= '0;
      bstart_r   <= 1'b0;
      iend_r     <= 1'b0;
      peak_vld_r <= '0;
      rd_vld_r   <= 1'b0;
      top_r      <= '0;
    end else begin
      rd_vld_r <= cmd.scan_rd;
      if (cmd.calc) begin
        bstart_r     <= bstart;
        iend_r       <= iend;
        last_stage_r <= st;
        vol_r        <= paused_r ? 32'sd0 : vol_nxt;
        ins_run_r    <= ins_nxt;
        exp_run_r    <= exp_nxt;
        top_r        <= '0;
        if (bstart) begin
          vte_r     <= vte_nxt;
          exp_rep_r <= exp_run_r;
        end
        if (iend) begin
          swept_r   <= arm_r - start_r;
          vti_r     <= vol_nxt;
          ins_rep_r <= ins_run_r[14:0];
        end else if (peep_mv) begin
          peep_r  <= peep_nxt;
          start_r <= arm_r;
        end
        if (st == ST_INS3) begin
          peak_vld_r[peak_slot_r] <= 1'b1;
          peak_slot_r             <= peak_slot_r + 1'b1;
        end
        if (st == ST_REST2) begin
          rest_r[rest_slot_r] <= quo;
          rest_slot_r         <= rest_slot_r + 1'b1;
        end
      end
      if (rd_vld_r) begin
        top_r <= top_nxt;
      end
      if (cmd.scan_fin) begin
        pip_r      <= top_nxt[14:0];
        peak_vld_r <= '0;
      end
    end
  end

  assign volume_ul      = vol_r;
  assign vti_ul         = vti_r;
  assign vte_ul         = vte_r;
  assign pip_centi      = pip_r;
  assign peep_centi     = peep_r;
  assign insp_flow_peak = ins_rep_r;
  assign exp_flow_peak  = exp_rep_r;
  assign swept_clicks   = swept_r;
  assign breath_start   = bstart_r;
  assign insp_end       = iend_r;

endmodule
`default_nettype wire

FILE: rtl/core/breath_cycle_metrics.sv
// top level of the per-sample breath metrics block
`timescale 1ns / 1ps
`default_nettype none
// channel | direction | handshake          | contents
// in_     | slave     | in_tvalid/tready   | one ventilator sample
// out_    | master    | out_tvalid/tready  | running volume and last breath metrics
//
// a sample that does not end inspiration goes from capture through the update
// state to the result; a sample that ends inspiration adds a scan of the 64-entry
// peak pressure ring through its single read port and a finish state, plus output wait
// one sample is in flight at a time, in_tready is high only while idle
// a held result stays in the output registers until out_tready
// rst_n is synchronous; metrics, rest ring, peak valid bits and stage history clear
module breath_cycle_metrics import bcm_pkg::*; (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [79:0]  in_tdata,   // flow_ml_s, pressure_centi, elapsed_ms, arm_position
  input  wire  [3:0]   in_tuser,   // stage, paused
  output logic         out_tvalid,
  input  wire          out_tready,
  output logic [191:0] out_tdata,  // volume_ul, vti_ul, vte_ul, pip_centi, peep_centi,
                                   // insp_flow_peak, exp_flow_peak, swept_clicks, pad
  output logic [1:0]   out_tuser   // breath_start, insp_end
);

  cmd_t cmd;
  sts_t sts;

  logic signed [31:0] volume_ul, vti_ul, vte_ul, swept_clicks;
  logic [14:0]        pip_centi, insp_flow_peak;
  logic signed [16:0] peep_centi;
  logic signed [15:0] exp_flow_peak;
  logic               breath_start, insp_end;

  // sequencer: owns the handshakes and the ring scan address
  bcm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // datapath: unpacked sample in, metric registers out
  bcm_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_stage          (in_tuser[2:0]),
    .in_flow_ml_s      (in_tdata[15:0]),
    .in_pressure_centi (in_tdata[31:16]),
    .in_elapsed_ms     (in_tdata[47:32]),
    .in_arm_position   (in_tdata[79:48]),
    .in_paused         (in_tuser[3]),
    .volume_ul         (volume_ul),
    .vti_ul            (vti_ul),
    .vte_ul            (vte_ul),
    .pip_centi         (pip_centi),
    .peep_centi        (peep_centi),
    .insp_flow_peak    (insp_flow_peak),
    .exp_flow_peak     (exp_flow_peak),
    .swept_clicks      (swept_clicks),
    .breath_start      (breath_start),
    .insp_end          (insp_end)
  );

  // result packing, lowest field first, one pad bit to a whole byte count
  assign out_tdata = {1'b0, swept_clicks, exp_flow_peak, insp_flow_peak, peep_centi,
                      pip_centi, vte_ul, vti_ul, volume_ul};
  assign out_tuser = {insp_end, breath_start};

endmodule
`default_nettype wire

FILE: rtl/core/bcm_checker.sv
// port-level checker for the breath cycle metrics block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module bcm_checker (
  input wire         clk,
  input wire         rst_n,
  input wire         in_tvalid,
  input wire         in_tready,
  input wire         out_tvalid,
  input wire         out_tready,
  input wire [191:0] out_tdata,
  input wire [1:0]   out_tuser
);

  // a stalled result transaction keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // one sample in flight: never accepting while a result is offered
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while result pending");

  // an accepted sample blocks further input in the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready && !out_tvalid)
    else $error("no processing gap after accept");

  // a breath start and an inspiration end never come from the same sample
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot0(out_tuser))
    else $error("both event flags set");

endmodule

bind breath_cycle_metrics bcm_checker u_bcm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
